@@ hdl/tdpt_pkg.sv @@
// Package for the trial-division prime tester.
// Holds the sequencer state type and its codes; depends on nothing.

package tdpt_pkg;

   typedef logic [1:0] state_type;

   localparam state_type ST_IDLE   = 2'd0;
   localparam state_type ST_DIVIDE = 2'd1;
   localparam state_type ST_CHECK  = 2'd2;
   localparam state_type ST_FINISH = 2'd3;

endpackage

@@ hdl/trial_division_prime_test.sv @@
// Trial-division prime tester: a sequencer around a bit-serial restoring divider.
// Depends on tdpt_pkg for the state type and codes.
//
// Usage:
//  - Request channel: req_valid, req_stall, req_candidate. A value is taken at a rising
//    edge with req_valid high and req_stall low. The candidate is a two's complement
//    integer of VALUE_WIDTH bits.
//  - Response channel: rsp_valid, rsp_stall, rsp_is_prime. One response per request,
//    in request order. rsp_is_prime is 1 only when the candidate is prime.
//  - One request is worked on at a time. req_stall is high from the transfer of a
//    request until its result has been moved into the response register.
//  - Negative values, 0, 1, 2 and even values are decided at once: the sequencer goes
//    straight to the finish state, which moves the result into the response register.
//  - Odd values try divisors 3, 5, 7, ... For each divisor the divider makes one quotient
//    bit per cycle, then the check state compares the quotient against the divisor and
//    tests the remainder. An item tries up to sqrt(value) / 2 divisors. At 32 bits the
//    worst case is about 23170 divisors.
//  - The response register parts the two sides: a new request is accepted while a
//    finished result waits on rsp_stall. A second result waits in the sequencer.
//  - Reset is synchronous and active high; it empties the sequencer and the response
//    register.

module trial_division_prime_test #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [VALUE_WIDTH-1:0] req_candidate,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_is_prime
);

   import tdpt_pkg::*;

   localparam int CNT_W = $clog2(VALUE_WIDTH);
   localparam logic [VALUE_WIDTH-1:0] VAL_ONE       = VALUE_WIDTH'(1);
   localparam logic [VALUE_WIDTH-1:0] VAL_TWO       = VALUE_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0] FIRST_DIVISOR = VALUE_WIDTH'(3);
   localparam logic [VALUE_WIDTH-1:0] DIVISOR_STEP  = VALUE_WIDTH'(2);
   localparam logic [CNT_W-1:0]       LAST_BIT      = CNT_W'(VALUE_WIDTH - 1);

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [VALUE_WIDTH-1:0] quot_ff, quot_in;
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] divisor_ff, divisor_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   result_ff, result_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_is_prime_ff, rsp_is_prime_in;

   logic                   req_xfer;
   logic                   rsp_xfer;
   logic [VALUE_WIDTH:0]   trial;
   logic [VALUE_WIDTH:0]   diff;
   logic                   fits;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_xfer     = req_valid && !req_stall;
   assign rsp_xfer     = rsp_valid_ff && !rsp_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // One restoring step: bring down the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, quot_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = (trial >= {1'b0, divisor_ff});

   always_comb begin
      state_in        = state_ff;
      value_in        = value_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      count_in        = count_ff;
      result_in       = result_ff;
      rsp_valid_in    = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_is_prime_in = rsp_is_prime_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               value_in   = req_candidate;
               quot_in    = req_candidate;
               rem_in     = '0;
               divisor_in = FIRST_DIVISOR;
               count_in   = LAST_BIT;
               result_in  = 1'b0;
               state_in   = ST_FINISH;
               if (req_candidate[VALUE_WIDTH-1]) begin
                  result_in = 1'b0;
               end else if (req_candidate == VAL_TWO) begin
                  result_in = 1'b1;
               end else if (req_candidate > VAL_ONE && req_candidate[0]) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in   = fits ? diff[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
            quot_in  = {quot_ff[VALUE_WIDTH-2:0], fits};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            // Divisor above the quotient means divisor squared exceeds the value.
            if (divisor_ff > quot_ff) begin
               result_in = 1'b1;
               state_in  = ST_FINISH;
            end else if (rem_ff == '0) begin
               result_in = 1'b0;
               state_in  = ST_FINISH;
            end else begin
               divisor_in = divisor_ff + DIVISOR_STEP;
               quot_in    = value_ff;
               rem_in     = '0;
               count_in   = LAST_BIT;
               state_in   = ST_DIVIDE;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in    = 1'b1;
               rsp_is_prime_in = result_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff        <= value_in;
      quot_ff         <= quot_in;
      rem_ff          <= rem_in;
      divisor_ff      <= divisor_in;
      count_ff        <= count_in;
      result_ff       <= result_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

`ifndef ASSERT_OFF
   a_count_steps: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE && count_ff != '0)
      |=> (state_ff == ST_DIVIDE && count_ff == $past(count_ff) - 1'b1))
      else $error("divider step count did not advance by one");

   a_divisor_odd: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE) |-> (divisor_ff[0] && divisor_ff >= FIRST_DIVISOR))
      else $error("trial divisor is not an odd value of at least three");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIVIDE || state_ff == ST_CHECK) |-> (rem_ff < divisor_ff))
      else $error("partial remainder reached the divisor");

   a_even_not_prime: assert property (@(posedge clock) disable iff (reset)
      (req_xfer && !req_candidate[0] && req_candidate != VAL_TWO)
      |=> (state_ff == ST_FINISH && !result_ff))
      else $error("even candidate other than two not rejected at once");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the finish state");
`endif

endmodule
